// ===== rtl/u8w_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16/UTF-32 transcoder.
`default_nettype none
package u8w_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [20:0] SUPP_BASE = 21'h010000;
	localparam logic [15:0] HI_SURR   = 16'hD800;
	localparam logic [5:0]  LO_SURR_TOP = 6'b110111; // 0xDC00 >> 10

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} u8w_byte_t;

	typedef struct packed {
		logic [20:0] code_unit;
		logic        is_error;
		logic        last;
	} u8w_unit_t;

	// Up to two result items produced by one input item.
	typedef struct packed {
		logic [1:0] n;
		u8w_unit_t  u0;
		u8w_unit_t  u1;
	} u8w_push_t;

endpackage
`default_nettype wire

// ===== rtl/u8w_decode.sv =====
// Input register, decode state and per-byte decode logic.
`default_nettype none
module u8w_decode (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	output logic                     byte_stall,
	input  wire u8w_pkg::u8w_byte_t  byte_item,
	input  wire logic                cfg_write_en,
	input  wire logic                cfg_write_data,
	input  wire logic                room2,
	output u8w_pkg::u8w_push_t       push
);
	import u8w_pkg::*;

	logic        valid_s1;
	u8w_byte_t   item_s1;
	logic        utf16_mode_q;
	logic [20:0] partial_q;
	logic [1:0]  due_q;
	logic        dropping_q;

	logic        fire;
	logic [20:0] partial_d;
	logic [1:0]  due_d;
	logic        dropping_d;
	logic [1:0]  due_m1;
	logic [20:0] cont_pp;
	logic [20:0] cp;
	logic        do_emit;
	logic        do_fail;
	logic [20:0] sup_off;
	logic [15:0] hi_unit;
	logic [2:0]  lead_payload;

	assign fire       = valid_s1 && room2;
	assign byte_stall = valid_s1 && !room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf16_mode_q <= 1'b0;
			partial_q    <= '0;
			due_q        <= '0;
			dropping_q   <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				utf16_mode_q <= cfg_write_data;
			end
			if (fire) begin
				partial_q  <= partial_d;
				due_q      <= due_d;
				dropping_q <= dropping_d;
			end
		end
	end

	assign due_m1 = due_q - 2'd1;

	always_comb begin
		cont_pp = partial_q;
		case (due_m1)
			2'd2:    cont_pp = partial_q | {3'd0, item_s1.data_byte[5:0], 12'd0};
			2'd1:    cont_pp = partial_q | {9'd0, item_s1.data_byte[5:0], 6'd0};
			default: cont_pp = partial_q | {15'd0, item_s1.data_byte[5:0]};
		endcase
	end

	// Next state and the emit / fail decision for the byte in s1.
	always_comb begin
		partial_d    = partial_q;
		due_d        = due_q;
		dropping_d   = dropping_q;
		cp           = '0;
		do_emit      = 1'b0;
		do_fail      = 1'b0;
		lead_payload = '0;
		if (dropping_q) begin
			dropping_d = !item_s1.end_of_string;
		end else if (due_q != 2'd0) begin
			if (due_m1 != 2'd0) begin
				if (item_s1.end_of_string) begin
					do_fail = 1'b1;
				end else begin
					due_d     = due_m1;
					partial_d = cont_pp;
				end
			end else begin
				cp        = cont_pp;
				do_emit   = 1'b1;
				due_d     = '0;
				partial_d = '0;
			end
		end else if (!item_s1.data_byte[7]) begin
			cp      = {13'd0, item_s1.data_byte};
			do_emit = 1'b1;
		end else if (!item_s1.data_byte[6]) begin
			do_fail = 1'b1;
		end else if (item_s1.data_byte[5] && item_s1.data_byte[4] && item_s1.data_byte[3]) begin
			do_fail = 1'b1;
		end else if (item_s1.end_of_string) begin
			do_fail = 1'b1;
		end else if (!item_s1.data_byte[5]) begin
			due_d     = 2'd1;
			partial_d = {10'd0, item_s1.data_byte[4:0], 6'd0};
		end else if (!item_s1.data_byte[4]) begin
			due_d     = 2'd2;
			partial_d = {5'd0, item_s1.data_byte[3:0], 12'd0};
		end else begin
			lead_payload = item_s1.data_byte[2:0];
			due_d        = 2'd3;
			partial_d    = {lead_payload, 18'd0};
		end
		if (do_fail) begin
			partial_d  = '0;
			due_d      = '0;
			dropping_d = !item_s1.end_of_string;
		end
	end

	assign sup_off = cp - SUPP_BASE;
	assign hi_unit = {5'd0, sup_off[20:10]} + HI_SURR;

	always_comb begin
		push = '0;
		if (fire) begin
			if (do_fail) begin
				push.n  = 2'd1;
				push.u0 = '{code_unit: '0, is_error: 1'b1, last: 1'b1};
			end else if (do_emit) begin
				if (utf16_mode_q && (cp >= SUPP_BASE)) begin
					push.n  = 2'd2;
					push.u0 = '{code_unit: {5'd0, hi_unit}, is_error: 1'b0, last: 1'b0};
					push.u1 = '{code_unit: {5'd0, LO_SURR_TOP, cp[9:0]}, is_error: 1'b0,
						last: item_s1.end_of_string};
				end else begin
					push.n  = 2'd1;
					push.u0 = '{code_unit: cp, is_error: 1'b0, last: item_s1.end_of_string};
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_drop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && dropping_q) |-> (push.n == 2'd0))
		else $error("result produced while dropping");
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0 && push.u0.is_error) |-> (push.n == 2'd1 && push.u0.last))
		else $error("error item not single and last");
	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.end_of_string) |=> (!dropping_q && due_q == 2'd0))
		else $error("state not clean after end of string");
`endif

endmodule
`default_nettype wire

// ===== rtl/u8w_queue.sv =====
// Small result queue that takes up to two items per cycle and drains one when the result side does not stall.
`default_nettype none
module u8w_queue #(
	parameter int DEPTH = u8w_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire u8w_pkg::u8w_push_t push,
	output logic                    room2,
	output logic                    unit_valid,
	input  wire logic               unit_stall,
	output u8w_pkg::u8w_unit_t      unit_item
);
	import u8w_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW:0]   DEPTH_C  = (CW + 1)'(DEPTH);

	u8w_unit_t   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;
	logic [PW-1:0] wr_ptr1, wr_ptr2;
	logic [CW:0]   space;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == LAST_PTR) ? '0 : p + PW'(1);
	endfunction

	assign pop        = unit_valid && !unit_stall;
	assign unit_valid = (count_q != '0);
	assign unit_item  = mem_q[rd_ptr_q];
	assign space      = DEPTH_C - {1'b0, count_q} + {{CW{1'b0}}, pop};
	assign room2      = (space >= (CW + 1)'(2));
	assign wr_ptr1    = ptr_inc(wr_ptr_q);
	assign wr_ptr2    = ptr_inc(wr_ptr1);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.u0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr1] <= push.u1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			case (push.n)
				2'd1:    wr_ptr_q <= wr_ptr1;
				2'd2:    wr_ptr_q <= wr_ptr2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push.n) - CW'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> room2)
		else $error("push without room");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} <= DEPTH_C)
		else $error("queue count beyond depth");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(unit_valid && unit_stall) |=> (unit_valid && $stable(unit_item)))
		else $error("stalled result item changed");
`endif

endmodule
`default_nettype wire

// ===== rtl/utf8_to_wide_transcoder.sv =====
// Top level of the UTF-8 to UTF-16/UTF-32 transcoder.
`default_nettype none
// Takes one UTF-8 byte per cycle while byte_stall is low and emits UTF-32 code
// points, or UTF-16 units when utf16_mode is set. Each byte passes an input
// register and combinational decode logic into the registered result queue.
// A byte can be taken every cycle; a surrogate pair writes two items into the
// result queue at once. The decode step waits while the queue has fewer than
// two free slots, so input is held off only when the result side stalls. A
// string found invalid (a stray continuation byte, a lead byte of 0xF8 to 0xFF,
// or an end of string inside a sequence) gives one error item marked last,
// then the bytes up to its end of string are discarded.
module utf8_to_wide_transcoder #(
	parameter int QueueDepth = u8w_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	output logic                    byte_stall,
	input  wire u8w_pkg::u8w_byte_t byte_item,
	output logic                    unit_valid,
	input  wire logic               unit_stall,
	output u8w_pkg::u8w_unit_t      unit_item,
	input  wire logic               cfg_write_en,
	input  wire logic               cfg_write_data
);
	import u8w_pkg::*;

	u8w_push_t push;
	logic      room2;

	u8w_decode u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.byte_item      (byte_item),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.room2          (room2),
		.push           (push)
	);

	u8w_queue #(
		.DEPTH (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room2      (room2),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.unit_item  (unit_item)
	);

endmodule
`default_nettype wire
